[hdl/hctr_pkg.sv]
// Package: shared constants, types and command structs for the hash-cons table.
package hctr_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int FRAME_DEPTH = 64;
    localparam int ARG_WIDTH   = 32;
    localparam int TRAIL_DEPTH = (2 * TABLE_DEPTH) / 3;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int FRAME_W     = $clog2(FRAME_DEPTH);
    localparam int FCOUNT_W    = $clog2(FRAME_DEPTH + 1);
    localparam int TRAIL_W     = $clog2(TRAIL_DEPTH);
    localparam int OCC_W       = $clog2(TRAIL_DEPTH + 1);

    localparam logic [1:0] KIND_INTERN = 2'd0;
    localparam logic [1:0] KIND_PUSH   = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CTOR = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_FRAMES   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CHECK,
        S_POPMARK,
        S_UNDO_RD,
        S_UNDO_CLR,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic hash_add;   // finish the home slot sum
        logic rd_slot;    // read the slot at the probe position
        logic step;       // advance the probe position
        logic insert;     // write the key and push the trail
        logic push;       // record a checkpoint mark
        logic pop_frame;  // drop the newest mark and load it
        logic rd_trail;   // read the newest trail entry
        logic clear_slot; // empty the slot just read from the trail
        logic sweep;      // empty the slot at sweep_idx after reset
        logic [SLOT_W-1:0] sweep_idx;
        logic [1:0] res_status;
        logic res_found;
        logic res_handle; // report the probe position as handle
        logic res_load;   // latch the result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic ctor_zero;
        logic slot_empty;
        logic slot_match;
        logic table_full;
        logic frames_full;
        logic above_mark;
    } dp_stat_t;

endpackage

[hdl/hctr_datapath.sv]
// Datapath: slot memories, undo trail, frame marks, hash and result register.
module hctr_datapath
    import hctr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [1:0]          kind,
    input  logic [7:0]          node_ctor,
    input  logic [31:0]         arg_first,
    input  logic [31:0]         arg_second,
    output dp_stat_t            stat,
    output logic [11:0]         handle,
    output logic                found_existing,
    output logic [1:0]          status,
    output logic [11:0]         occupied_count,
    output logic [6:0]          open_frames
);

    logic [7:0]            ctor_mem [TABLE_DEPTH];
    logic [2*ARG_WIDTH-1:0] args_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0]     trail_mem [TRAIL_DEPTH];
    logic [OCC_W-1:0]      mark_mem [FRAME_DEPTH];

    // Epoch-free clear: a validity bit memory swept by reset is avoided by
    // clearing with a pass after reset; the controller waits on clr_busy.
    logic [1:0]           kind_reg;
    logic [7:0]           ctor_reg;
    logic [ARG_WIDTH-1:0] a_reg, b_reg;
    logic [SLOT_W-1:0]    prod_a_reg, prod_b_reg, pos_reg;
    logic [7:0]           rd_ctor_reg;
    logic [2*ARG_WIDTH-1:0] rd_args_reg;
    logic [SLOT_W-1:0]    trail_rd_reg;
    logic [OCC_W-1:0]     occ_reg, mark_reg;
    logic [FCOUNT_W-1:0]  fcnt_reg;
    logic [11:0]          handle_reg, occ_out_reg;
    logic                 found_reg;
    logic [1:0]           status_reg;
    logic [6:0]           frames_out_reg;

    // Only the low SLOT_W bits of the products matter for the power-of-two modulo.
    logic [SLOT_W-1:0] pa_next, pb_next;
    assign pa_next = SLOT_W'(arg_first[ARG_WIDTH-1:0] * 32'd729);
    assign pb_next = SLOT_W'(arg_second[ARG_WIDTH-1:0] * 32'd125);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            ctor_reg   <= node_ctor;
            a_reg      <= arg_first[ARG_WIDTH-1:0];
            b_reg      <= arg_second[ARG_WIDTH-1:0];
            prod_a_reg <= pa_next;
            prod_b_reg <= pb_next;
        end
        if (cmd.hash_add)
            pos_reg <= SLOT_W'(ctor_reg) + prod_a_reg + prod_b_reg;
        else if (cmd.step)
            pos_reg <= pos_reg + 1'b1;
        if (cmd.rd_slot)
        begin
            rd_ctor_reg <= ctor_mem[pos_reg];
            rd_args_reg <= args_mem[pos_reg];
        end
        if (cmd.insert)
        begin
            ctor_mem[pos_reg] <= ctor_reg;
            args_mem[pos_reg] <= {a_reg, b_reg};
            trail_mem[TRAIL_W'(occ_reg)] <= pos_reg;
        end
        else if (cmd.clear_slot)
            ctor_mem[trail_rd_reg] <= 8'd0;
        else if (cmd.sweep)
            ctor_mem[cmd.sweep_idx] <= 8'd0;
        if (cmd.push)
            mark_mem[FRAME_W'(fcnt_reg)] <= occ_reg;
        // A pop with no open frames rolls back to empty.
        if (cmd.pop_frame)
        begin
            if (fcnt_reg == '0)
                mark_reg <= '0;
            else
                mark_reg <= mark_mem[FRAME_W'(fcnt_reg - 1'b1)];
        end
        if (cmd.rd_trail)
            trail_rd_reg <= trail_mem[TRAIL_W'(occ_reg - 1'b1)];
        if (cmd.res_load)
        begin
            handle_reg     <= cmd.res_handle ? 12'(pos_reg) : 12'd0;
            found_reg      <= cmd.res_found;
            status_reg     <= cmd.res_status;
        end
    end

    // Counters are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            fcnt_reg <= '0;
        end
        else
        begin
            if (cmd.insert)
                occ_reg <= occ_reg + 1'b1;
            else if (cmd.rd_trail)
                occ_reg <= occ_reg - 1'b1;
            if (cmd.push)
                fcnt_reg <= fcnt_reg + 1'b1;
            else if (cmd.pop_frame && fcnt_reg != '0)
                fcnt_reg <= fcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            occ_out_reg    <= 12'(occ_reg + (cmd.insert ? 1'b1 : 1'b0));
            frames_out_reg <= 7'(fcnt_reg + (cmd.push ? 1'b1 : 1'b0));
        end
    end

    logic [OCC_W-1:0] mark_eff;
    assign mark_eff = mark_reg;

    assign stat.kind        = kind_reg;
    assign stat.ctor_zero   = (ctor_reg == 8'd0);
    assign stat.slot_empty  = (rd_ctor_reg == 8'd0);
    assign stat.slot_match  = (rd_ctor_reg == ctor_reg) && (rd_args_reg == {a_reg, b_reg});
    assign stat.table_full  = (occ_reg >= OCC_W'(TRAIL_DEPTH));
    assign stat.frames_full = (fcnt_reg >= FCOUNT_W'(FRAME_DEPTH));
    assign stat.above_mark  = (occ_reg > mark_eff);

    assign handle         = handle_reg;
    assign found_existing = found_reg;
    assign status         = status_reg;
    assign occupied_count = occ_out_reg;
    assign open_frames    = frames_out_reg;

endmodule

[hdl/hctr_control.sv]
// Controller: sequences probing, insertion, checkpoints and rollback.
module hctr_control
    import hctr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   clr_busy_reg;
    logic [SLOT_W-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SLOT_W'(TABLE_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    // Output may be accepted at the same edge that takes the next item.
    logic out_valid_reg;
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !clr_busy_reg && out_free;

    logic done_pulse;
    assign done_pulse = cmd.res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done_pulse)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                    state_next = S_HASH;
            S_HASH:
                case (stat.kind)
                    KIND_INTERN: state_next = stat.ctor_zero ? S_DONE : S_PROBE;
                    KIND_POP:    state_next = S_POPMARK;
                    default:     state_next = S_DONE;
                endcase
            S_PROBE:   state_next = S_CHECK;
            S_CHECK:
                if (stat.slot_empty || stat.slot_match)
                    state_next = S_DONE;
                else
                    state_next = S_PROBE;
            S_POPMARK: state_next = S_UNDO_RD;
            S_UNDO_RD: state_next = stat.above_mark ? S_UNDO_CLR : S_DONE;
            S_UNDO_CLR: state_next = S_UNDO_RD;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
                cmd.load = in_valid && in_ready;
            S_HASH:
            begin
                cmd.hash_add = 1'b1;
                case (stat.kind)
                    KIND_INTERN:
                        if (stat.ctor_zero)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_BAD_CTOR;
                        end
                    KIND_PUSH:
                    begin
                        cmd.res_load = 1'b1;
                        if (stat.frames_full)
                            cmd.res_status = ST_FRAMES;
                        else
                            cmd.push = 1'b1;
                    end
                    KIND_POP:
                        cmd.pop_frame = 1'b1;
                    default:
                        cmd.res_load = 1'b1;
                endcase
            end
            S_PROBE:
                cmd.rd_slot = 1'b1;
            S_CHECK:
                if (stat.slot_match && !stat.slot_empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_found  = 1'b1;
                    cmd.res_handle = 1'b1;
                end
                else if (stat.slot_empty)
                begin
                    cmd.res_load = 1'b1;
                    if (stat.table_full)
                        cmd.res_status = ST_FULL;
                    else
                    begin
                        cmd.insert     = 1'b1;
                        cmd.res_handle = 1'b1;
                    end
                end
                else
                    cmd.step = 1'b1;
            S_UNDO_RD:
                if (stat.above_mark)
                    cmd.rd_trail = 1'b1;
                else
                    cmd.res_load = 1'b1;
            S_UNDO_CLR:
                cmd.clear_slot = 1'b1;
            default:
                cmd = '0;
        endcase
        // The post-reset sweep shares the slot write port while no item runs.
        if (clr_busy_reg)
        begin
            cmd.sweep     = 1'b1;
            cmd.sweep_idx = clr_idx_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ready)
        else $error("item taken during clearing sweep");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");
    a_ins_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> stat.slot_empty && !stat.table_full)
        else $error("insert into occupied slot");
`endif

endmodule

[hdl/hash_cons_table_with_rollback.sv]
// Top level: hash-consing table with checkpoint and rollback.
// Hash-consing table of 4096 slots, keyed by (node_ctor, arg_first,
// arg_second). An intern item is loaded and hashed to its home slot, then
// probes slots in turn, each read then checked, up to an empty or matching
// slot, then posts its result. A push, a bad constructor or an unused kind
// posts its result after the hash step. A pop loads its mark, then walks the
// undo trail newest first, reading and clearing each entry above the mark.
// After reset the block sweeps the slot table empty and takes no item until
// done. One result per item, held in a result register; the next item
// transfers in only once the last result has gone or goes at the same edge.
// Handles are slot indices; every nonzero status answers handle 0.
module hash_cons_table_with_rollback
    import hctr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  node_ctor,
    input  logic [31:0] arg_first,
    input  logic [31:0] arg_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] handle,
    output logic        found_existing,
    output logic [1:0]  status,
    output logic [11:0] occupied_count,
    output logic [6:0]  open_frames
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each transfer; drive the datapath by command.
    hctr_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the table, trail, marks and result register.
    hctr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .kind             (kind),
        .node_ctor        (node_ctor),
        .arg_first        (arg_first),
        .arg_second       (arg_second),
        .stat             (stat),
        .handle           (handle),
        .found_existing   (found_existing),
        .status           (status),
        .occupied_count   (occupied_count),
        .open_frames      (open_frames)
    );

endmodule
